// ----- rtl/core/ipv4_wildcard_dotted_parser_defines.svh -----
// ============================================================================
// ipv4_wildcard_dotted_parser_defines.svh
// Assertion macros shared by the dotted-quad parser RTL.
// ============================================================================
`ifndef IPV4_WILDCARD_DOTTED_PARSER_DEFINES_SVH
`define IPV4_WILDCARD_DOTTED_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IWDP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IWDP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/iwdp_pkg.sv -----
// ============================================================================
// iwdp_pkg
// Types and constants of the wildcard dotted-quad IPv4 parser.
// ============================================================================
`default_nettype none

package iwdp_pkg;

    localparam logic [7:0]  CH_ZERO      = 8'h30;
    localparam logic [7:0]  CH_NINE      = 8'h39;
    localparam logic [7:0]  CH_DOT       = 8'h2E;
    localparam logic [7:0]  CH_STAR      = 8'h2A;
    localparam logic [7:0]  OCTET_ALL    = 8'hFF;
    localparam logic [11:0] OCTET_LIMIT  = 12'd255;
    localparam logic [2:0]  MAX_ELEMENTS = 3'd4;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_TOO_MANY     = 3'd1,
        ERR_LEADING_ZERO = 3'd2,
        ERR_OVERFLOW     = 3'd3,
        ERR_BAD_CHAR     = 3'd4,
        ERR_TOO_FEW      = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        WC_NONE = 2'd0,
        WC_DOT  = 2'd1,
        WC_STAR = 2'd2
    } wc_phase_t;

    typedef struct packed {
        logic            digit_seen;
        logic [2:0]      element_count;
        logic [1:0]      byte_position;
        logic [3:0][7:0] address_bytes;
        logic [3:0]      wildcard_marks;
        wc_phase_t       wildcard_phase;
        err_t            first_error;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        digit_seen:     1'b0,
        element_count:  3'd0,
        byte_position:  2'd0,
        address_bytes:  '0,
        wildcard_marks: 4'd0,
        wildcard_phase: WC_NONE,
        first_error:    ERR_NONE
    };

    typedef struct packed {
        err_t        error_kind;
        logic [31:0] mask;
        logic [31:0] address;
        logic        valid_res;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/iwdp_step.sv -----
// ============================================================================
// iwdp_step
// Next-state and result logic for one character of the address text.
// ============================================================================
`default_nettype none

module iwdp_step
    import iwdp_pkg::*;
(
    input  parse_state_t cur_state,
    input  logic [7:0]   char_code,
    input  logic         is_last,
    output parse_state_t state_next,
    output result_t      result
);

    parse_state_t nx;
    logic [1:0]   pos;
    logic [1:0]   pos_inc;
    logic [7:0]   cur;
    logic [11:0]  val;
    logic [7:0]   digit_full;
    logic         is_digit;
    logic         count_full;

    always_comb
    begin
        nx         = cur_state;
        pos        = cur_state.byte_position;
        pos_inc    = pos + 2'd1;
        cur        = cur_state.address_bytes[pos];
        digit_full = char_code - CH_ZERO;
        // cur * 10 + digit
        val        = {1'b0, cur, 3'b000} + {3'b000, cur, 1'b0} + {8'd0, digit_full[3:0]};
        is_digit   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        count_full = cur_state.element_count >= MAX_ELEMENTS;

        // Once an error is latched, ignore the rest of the text.
        if (cur_state.first_error == ERR_NONE)
        begin
            case (cur_state.wildcard_phase)
                WC_DOT:
                begin
                    if (count_full)
                    begin
                        nx.first_error = ERR_TOO_MANY;
                    end
                    else
                    begin
                        nx.element_count = cur_state.element_count + 3'd1;
                        if (char_code != CH_DOT)
                            nx.first_error = ERR_BAD_CHAR;
                        else
                            nx.wildcard_phase = WC_STAR;
                    end
                end
                WC_STAR:
                begin
                    if (char_code != CH_STAR)
                    begin
                        nx.first_error = ERR_BAD_CHAR;
                    end
                    else
                    begin
                        nx.byte_position           = pos_inc;
                        nx.address_bytes[pos_inc]  = OCTET_ALL;
                        nx.wildcard_marks[pos_inc] = 1'b1;
                        nx.wildcard_phase          = WC_DOT;
                    end
                end
                default:
                begin
                    if (char_code == CH_STAR && !cur_state.digit_seen)
                    begin
                        if (count_full)
                        begin
                            nx.first_error = ERR_TOO_MANY;
                        end
                        else
                        begin
                            nx.element_count       = cur_state.element_count + 3'd1;
                            nx.address_bytes[pos]  = OCTET_ALL;
                            nx.wildcard_marks[pos] = 1'b1;
                            nx.wildcard_phase      = WC_DOT;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (cur_state.digit_seen && cur == 8'd0)
                        begin
                            nx.first_error = ERR_LEADING_ZERO;
                        end
                        else if (val > OCTET_LIMIT)
                        begin
                            nx.first_error = ERR_OVERFLOW;
                        end
                        else
                        begin
                            nx.address_bytes[pos] = val[7:0];
                            if (!cur_state.digit_seen && count_full)
                            begin
                                nx.first_error = ERR_TOO_MANY;
                            end
                            else
                            begin
                                if (!cur_state.digit_seen)
                                    nx.element_count = cur_state.element_count + 3'd1;
                                nx.digit_seen = 1'b1;
                            end
                        end
                    end
                    else if (char_code == CH_DOT && cur_state.digit_seen)
                    begin
                        if (count_full)
                        begin
                            nx.first_error = ERR_TOO_MANY;
                        end
                        else
                        begin
                            nx.byte_position           = pos_inc;
                            nx.address_bytes[pos_inc]  = 8'd0;
                            nx.wildcard_marks[pos_inc] = 1'b0;
                            nx.digit_seen              = 1'b0;
                        end
                    end
                    else
                    begin
                        nx.first_error = ERR_BAD_CHAR;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        result.error_kind = nx.first_error;
        if (nx.first_error == ERR_NONE
            && (nx.wildcard_phase == WC_STAR || nx.element_count < MAX_ELEMENTS))
            result.error_kind = ERR_TOO_FEW;
        result.valid_res = (result.error_kind == ERR_NONE);
        if (result.valid_res)
        begin
            result.address = {nx.address_bytes[0], nx.address_bytes[1],
                              nx.address_bytes[2], nx.address_bytes[3]};
            result.mask    = {{8{~nx.wildcard_marks[0]}}, {8{~nx.wildcard_marks[1]}},
                              {8{~nx.wildcard_marks[2]}}, {8{~nx.wildcard_marks[3]}}};
        end
        else
        begin
            result.address = 32'd0;
            result.mask    = 32'd0;
        end
    end

    // Start the next text from a clean state.
    assign state_next = is_last ? STATE_RESET : nx;

endmodule

`default_nettype wire

// ----- rtl/core/ipv4_wildcard_dotted_parser.sv -----
// ============================================================================
// ipv4_wildcard_dotted_parser
// Streaming parser for dotted-quad IPv4 text with '*' wildcard elements.
// ============================================================================
// The block takes one ASCII character per transaction, with tlast on the final
// character, and returns one result transaction per text: valid flag, 32-bit
// address, 32-bit mask and the first error seen. One character is taken every
// cycle unless a closing character is held back; the character goes through an
// input register, combinational parse logic updates the parse state, and the
// result lands in an output register, from which it is offered on m_tvalid.
// A closing character waits in the input register only while the previous
// result is still held unaccepted in the output register. The parse state
// update, once per character, sets the rate.
`default_nettype none

`include "ipv4_wildcard_dotted_parser_defines.svh"

module ipv4_wildcard_dotted_parser
    import iwdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [0] valid_res, [32:1] address, [64:33] mask,
                                   // [67:65] error_kind, [71:68] zero
);

    logic         in_valid_reg;
    logic         in_valid_next;
    logic [7:0]   char_reg;
    logic         last_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    logic         out_valid_reg;
    logic         out_valid_next;
    result_t      out_reg;
    result_t      step_result;
    logic         out_free;
    logic         advance;

    iwdp_step u_step (
        .cur_state  (state_reg),
        .char_code  (char_reg),
        .is_last    (last_reg),
        .state_next (step_state),
        .result     (step_result)
    );

    // A closing character moves only when the result register can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;
        state_next    = advance ? step_state : state_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            last_reg <= s_tlast;
        end
        if (advance && last_reg)
            out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.error_kind, out_reg.mask, out_reg.address,
                       out_reg.valid_res};

    `IWDP_ASSERT_NOW(a_valid_matches_error, clk, rst_n, out_valid_reg,
        out_reg.valid_res == (out_reg.error_kind == ERR_NONE),
        "valid flag disagrees with error code")
    `IWDP_ASSERT_NOW(a_invalid_zero_fields, clk, rst_n, out_valid_reg && !out_reg.valid_res,
        out_reg.address == 32'd0 && out_reg.mask == 32'd0,
        "rejected text carries nonzero address or mask")
    `IWDP_ASSERT_NEXT(a_state_cleared_after_text, clk, rst_n, advance && last_reg,
        state_reg == STATE_RESET && out_valid_reg,
        "parse state not cleared or result missing after closing character")
    `IWDP_ASSERT_NOW(a_element_count_bound, clk, rst_n, 1'b1,
        state_reg.element_count <= MAX_ELEMENTS,
        "element count beyond four")

endmodule

`default_nettype wire

// ----- bench/ipv4_wildcard_dotted_parser_test.sv -----
// ============================================================================
// ipv4_wildcard_dotted_parser_test
// Self-checking bench for the wildcard dotted-quad IPv4 text parser.
// ============================================================================
// Streams ASCII characters into the parser, one per transaction, with tlast on
// the final character of each text. A short directed set covers the extremes
// and each error kind. It is followed by random texts: mostly well-formed
// quads with random octets and wildcard tails, and partly broken or noisy
// texts. An in-bench parse model predicts one verdict per text. The monitor
// compares every output transaction field by field. Both sides idle at random.
// The output side also holds off once for a long stretch, and the input side
// pauses now and then until every verdict has come back.

module ipv4_wildcard_dotted_parser_test;
    import iwdp_pkg::*;

    localparam int unsigned ITEM_COUNT  = 1350;
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned HOLD_AFTER  = 40;
    localparam int unsigned TAIL_CYCLES = 20;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       drain;
    } char_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    char_item_t  text_chars [$];
    result_t     verdicts_due [$];
    int unsigned verdicts_due_count = 0;
    int unsigned fail_count = 0;

    // parse model state
    logic       pm_digit;
    logic [2:0] pm_count;
    logic [1:0] pm_slot;
    logic [7:0] pm_bytes [4];
    logic [3:0] pm_wild;
    wc_phase_t  pm_phase;
    err_t       pm_err;

    ipv4_wildcard_dotted_parser u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got 0x%08h expected 0x%08h", what, got, want);
        fail_count++;
    endtask

    function automatic void clear_parse();
        pm_digit = 1'b0;
        pm_count = '0;
        pm_slot  = '0;
        for (int i = 0; i < 4; i++)
            pm_bytes[i] = '0;
        pm_wild  = '0;
        pm_phase = WC_NONE;
        pm_err   = ERR_NONE;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        logic [11:0] acc;
        if (pm_phase == WC_DOT)
        begin
            if (pm_count >= MAX_ELEMENTS)
            begin
                pm_err = ERR_TOO_MANY;
                return;
            end
            pm_count++;
            if (c != CH_DOT)
            begin
                pm_err = ERR_BAD_CHAR;
                return;
            end
            pm_phase = WC_STAR;
            return;
        end
        if (pm_phase == WC_STAR)
        begin
            if (c != CH_STAR)
            begin
                pm_err = ERR_BAD_CHAR;
                return;
            end
            pm_slot++;
            pm_bytes[pm_slot] = OCTET_ALL;
            pm_wild[pm_slot]  = 1'b1;
            pm_phase = WC_DOT;
            return;
        end

        if (c == CH_STAR && !pm_digit)
        begin
            if (pm_count >= MAX_ELEMENTS)
            begin
                pm_err = ERR_TOO_MANY;
                return;
            end
            pm_count++;
            pm_bytes[pm_slot] = OCTET_ALL;
            pm_wild[pm_slot]  = 1'b1;
            pm_phase = WC_DOT;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            acc = 12'(pm_bytes[pm_slot]) * 12'd10 + 12'(c - CH_ZERO);
            if (pm_digit && pm_bytes[pm_slot] == 8'd0)
            begin
                pm_err = ERR_LEADING_ZERO;
                return;
            end
            if (acc > OCTET_LIMIT)
            begin
                pm_err = ERR_OVERFLOW;
                return;
            end
            pm_bytes[pm_slot] = acc[7:0];
            if (!pm_digit)
            begin
                if (pm_count >= MAX_ELEMENTS)
                begin
                    pm_err = ERR_TOO_MANY;
                    return;
                end
                pm_count++;
            end
            pm_digit = 1'b1;
        end
        else if (c == CH_DOT && pm_digit)
        begin
            if (pm_count >= MAX_ELEMENTS)
            begin
                pm_err = ERR_TOO_MANY;
                return;
            end
            pm_slot++;
            pm_bytes[pm_slot] = 8'd0;
            pm_wild[pm_slot]  = 1'b0;
            pm_digit = 1'b0;
        end
        else
        begin
            pm_err = ERR_BAD_CHAR;
        end
    endfunction

    // Feed one accepted character; returns 1 with the verdict on the last one.
    function automatic bit predict_verdict(input logic [7:0] c, input logic last,
                                           output result_t verdict);
        verdict = '0;
        if (pm_err == ERR_NONE)
            parse_char(c);
        if (!last)
            return 1'b0;
        if (pm_err == ERR_NONE && (pm_phase == WC_STAR || pm_count < MAX_ELEMENTS))
            pm_err = ERR_TOO_FEW;
        if (pm_err == ERR_NONE)
        begin
            verdict.valid_res = 1'b1;
            for (int i = 0; i < 4; i++)
            begin
                verdict.address = {verdict.address[23:0], pm_bytes[i]};
                verdict.mask    = {verdict.mask[23:0], pm_wild[i] ? 8'h00 : OCTET_ALL};
            end
        end
        verdict.error_kind = pm_err;
        clear_parse();
        return 1'b1;
    endfunction

    function automatic void push_chars(input logic [7:0] txt[$], input bit drain);
        char_item_t item;
        for (int i = 0; i < txt.size(); i++)
        begin
            item.ch    = txt[i];
            item.last  = (i == txt.size() - 1);
            item.drain = drain && (i == 0);
            text_chars.push_back(item);
        end
    endfunction

    function automatic void push_str(input string s);
        logic [7:0] txt[$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        push_chars(txt, 1'b0);
    endfunction

    function automatic void append_number(ref logic [7:0] txt[$], input int unsigned v);
        if (v >= 100)
            txt.push_back(CH_ZERO + 8'(v / 100));
        if (v >= 10)
            txt.push_back(CH_ZERO + 8'((v / 10) % 10));
        txt.push_back(CH_ZERO + 8'(v % 10));
    endfunction

    // Stimulus and end of run
    initial
    begin
        logic [7:0]  txt[$];
        logic [7:0]  pick;
        int unsigned kind;
        int unsigned n_el;
        int unsigned wild_from;
        int unsigned pos;
        int unsigned text_no;

        clear_parse();

        push_str("255.0.9.*");
        push_str("*.*.*.*");
        push_str("*.*.*.*.");
        push_str("01");
        push_str("256");
        push_str("1..*");
        push_str("1.*.");
        txt = '{8'h00};
        push_chars(txt, 1'b0);

        text_no = 0;
        while (text_chars.size() < ITEM_COUNT)
        begin
            txt.delete();
            kind = $urandom_range(0, 99);
            if (kind < 6)
            begin
                repeat ($urandom_range(1, 8))
                    txt.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                n_el = (kind < 14) ? $urandom_range(1, 6) : 4;
                wild_from = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n_el - 1) : n_el;
                for (int e = 0; e < n_el; e++)
                begin
                    if (e > 0)
                        txt.push_back(CH_DOT);
                    if (e >= wild_from)
                        txt.push_back(CH_STAR);
                    else
                    begin
                        case ($urandom_range(0, 9))
                            6:       append_number(txt, $urandom_range(250, 255));
                            7:       append_number(txt, $urandom_range(256, 999));
                            8:
                            begin
                                txt.push_back(CH_ZERO);
                                append_number(txt, $urandom_range(0, 99));
                            end
                            9:       append_number(txt, 0);
                            default: append_number(txt, $urandom_range(0, 255));
                        endcase
                    end
                end
                // break the text in one spot
                if (kind < 30)
                begin
                    case ($urandom_range(0, 3))
                        0:       pick = CH_DOT;
                        1:       pick = CH_STAR;
                        2:       pick = CH_ZERO + 8'($urandom_range(0, 9));
                        default: pick = 8'($urandom_range(0, 255));
                    endcase
                    pos = $urandom_range(0, txt.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       txt[pos] = pick;
                        1:       txt.delete(pos);
                        default: txt.insert(pos, pick);
                    endcase
                    if (txt.size() == 0)
                        txt.push_back(pick);
                end
            end
            push_chars(txt, (text_no % 30) == 0);
            text_no++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (text_chars.size() != 0 || s_tvalid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Driver: bursts of characters with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        char_item_t item;
        logic       offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            // hold the current character until its transaction completes
            offer = s_tvalid && !s_tready;
            if (!offer)
            begin
                if (gap_left != 0)
                    gap_left--;
                // a closing character taken at this edge still owes a verdict
                else if (text_chars.size() != 0
                         && !(text_chars[0].drain
                              && (verdicts_due_count != 0
                                  || (s_tvalid && s_tready && s_tlast))))
                begin
                    item = text_chars.pop_front();
                    s_tdata <= item.ch;
                    s_tlast <= item.last;
                    offer = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Monitor: predict on input transactions, check output transactions,
    // and drive the output-side stall pattern.
    int unsigned verdicts_seen = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned stall_mode    = 0;
    int unsigned mode_left     = 0;

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        logic    ready_next;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                verdicts_seen++;
                if (verdicts_due.size() == 0)
                    flag_mismatch("result with nothing expected", m_tdata[32:1], 32'd0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[0] !== want.valid_res)
                        flag_mismatch("valid_res", 32'(m_tdata[0]), 32'(want.valid_res));
                    if (m_tdata[32:1] !== want.address)
                        flag_mismatch("address", m_tdata[32:1], want.address);
                    if (m_tdata[64:33] !== want.mask)
                        flag_mismatch("mask", m_tdata[64:33], want.mask);
                    if (m_tdata[67:65] !== want.error_kind)
                        flag_mismatch("error_kind", 32'(m_tdata[67:65]),
                                      32'(want.error_kind));
                    if (m_tdata[71:68] !== 4'd0)
                        flag_mismatch("pad bits", 32'(m_tdata[71:68]), 32'd0);
                end
            end
            if (s_tvalid && s_tready && predict_verdict(s_tdata, s_tlast, want))
                verdicts_due.push_back(want);
            verdicts_due_count <= verdicts_due.size();

            // one long hold-off so the parser backs up into its input
            if (!hold_done && verdicts_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(10, 80);
                end
                else
                    mode_left--;
                case (stall_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    default: ready_next = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= ready_next;
        end
    end

    // Watchdog: end the run if no transaction completes for too long
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
